/* sv/b32d_pkg.sv */
// b32d_pkg: shared types and constants of the base32hex stream decoder.
// Holds the result-kind codes, the character class struct and the result struct.
// No dependencies; imported by every module of the decoder.
package b32d_pkg;

  // Result kinds carried on the output channel
  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_OK   = 2'd1,
    KIND_FAIL = 2'd2
  } kind_e;

  // ASCII anchors of the alphabet
  localparam logic [7:0] ChDigit0 = 8'h30;  // '0'
  localparam logic [7:0] ChDigit9 = 8'h39;  // '9'
  localparam logic [7:0] ChUpperA = 8'h41;  // 'A'
  localparam logic [7:0] ChUpperV = 8'h56;  // 'V'
  localparam logic [7:0] ChLowerA = 8'h61;  // 'a'
  localparam logic [7:0] ChLowerV = 8'h76;  // 'v'
  localparam logic [7:0] ChPad    = 8'h3D;  // '='
  localparam logic [7:0] ChSpace  = 8'h20;  // ' '
  localparam logic [7:0] ChTab    = 8'h09;  // first control whitespace
  localparam logic [7:0] ChCr     = 8'h0D;  // last control whitespace
  // Offsets that map a letter straight to 10..31
  localparam logic [7:0] UpperOfs = 8'h37;
  localparam logic [7:0] LowerOfs = 8'h57;

  localparam int unsigned CountW = 16;

  // Classification of one character
  typedef struct packed {
    logic       is_sym;  // alphabet symbol, value in sym
    logic       is_skip; // pad or whitespace
    logic [4:0] sym;
  } char_class_t;

  // One result item computed from the input stage
  typedef struct packed {
    logic              valid;
    kind_e             kind;
    logic [7:0]        data;
    logic [CountW-1:0] count;
  } result_t;

endpackage

/* sv/b32d_char_class.sv */
// b32d_char_class: maps one ASCII code to a 5-bit symbol, a skip flag or junk.
// Pure combinational decode of the base32hex alphabet.
// Depends on b32d_pkg.
module b32d_char_class (
  input  logic [7:0]            ch_i,
  output b32d_pkg::char_class_t class_o
);
  import b32d_pkg::*;

  logic is_digit, is_upper, is_lower;
  logic [7:0] ofs;

  assign is_digit = (ch_i >= ChDigit0) && (ch_i <= ChDigit9);
  assign is_upper = (ch_i >= ChUpperA) && (ch_i <= ChUpperV);
  assign is_lower = (ch_i >= ChLowerA) && (ch_i <= ChLowerV);

  // Subtract the range base; only the low five bits matter
  always_comb begin
    if (is_digit) begin
      ofs = ch_i - ChDigit0;
    end else if (is_upper) begin
      ofs = ch_i - UpperOfs;
    end else begin
      ofs = ch_i - LowerOfs;
    end
  end

  assign class_o.is_sym  = is_digit || is_upper || is_lower;
  assign class_o.is_skip = (ch_i == ChPad) || (ch_i == ChSpace) ||
                           ((ch_i >= ChTab) && (ch_i <= ChCr));
  assign class_o.sym     = ofs[4:0];

endmodule

/* sv/b32d_packer.sv */
// b32d_packer: per-string state (phase, leftover bits, byte count, error flag)
// and the bit packing that turns 5-bit symbols into bytes, MSB first.
// Depends on b32d_pkg.
module b32d_packer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,    // stage item is consumed this cycle
  input  logic                        last_i,
  input  b32d_pkg::char_class_t       class_i,
  input  logic [b32d_pkg::CountW-1:0] limit_i,
  output b32d_pkg::result_t           res_o
);
  import b32d_pkg::*;

  logic [2:0]        phase_q, phase_d;
  logic [7:0]        partial_q, partial_d;
  logic [CountW-1:0] bytes_q, bytes_d;
  logic              failed_q, failed_d;

  logic [2:0]  pending;
  logic [11:0] acc;
  logic [3:0]  nbits;
  logic [2:0]  rest;
  logic [11:0] shifted;
  logic [7:0]  rest_mask;
  logic [CountW-1:0] bytes_inc;

  // Bits left over from earlier symbols: (5 * phase) mod 8
  assign pending   = phase_q + {phase_q[0], 2'b00};
  assign acc       = {partial_q[6:0], class_i.sym};
  assign nbits     = {1'b0, pending} + 4'd5;
  assign rest      = nbits[2:0];  // nbits - 8 when a byte completes
  assign shifted   = acc >> rest;
  assign rest_mask = 8'((9'd1 << rest) - 9'd1);
  assign bytes_inc = bytes_q + 1'b1;

  // Next state and result
  always_comb begin
    phase_d   = phase_q;
    partial_d = partial_q;
    bytes_d   = bytes_q;
    failed_d  = failed_q;
    res_o     = '{valid: 1'b0, kind: KIND_DATA, data: 8'd0, count: '0};
    if (adv_i) begin
      if (last_i) begin
        res_o.valid = 1'b1;
        res_o.kind  = failed_q ? KIND_FAIL : KIND_OK;
        res_o.count = failed_q ? '0 : bytes_q;
        phase_d     = '0;
        partial_d   = '0;
        bytes_d     = '0;
        failed_d    = 1'b0;
      end else if (!failed_q && !class_i.is_skip) begin
        if (!class_i.is_sym || (bytes_q >= limit_i)) begin
          failed_d = 1'b1;
        end else begin
          phase_d = phase_q + 3'd1;
          if (nbits[3]) begin
            partial_d   = acc[7:0] & rest_mask;
            bytes_d     = bytes_inc;
            res_o.valid = 1'b1;
            res_o.data  = shifted[7:0];
            res_o.count = bytes_inc;
          end else begin
            partial_d = acc[7:0];
          end
        end
      end
    end
  end

  // String state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= '0;
      partial_q <= '0;
      bytes_q   <= '0;
      failed_q  <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      partial_q <= partial_d;
      bytes_q   <= bytes_d;
      failed_q  <= failed_d;
    end
  end

`ifndef SYNTHESIS
  // An end item leaves a clean string state behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && last_i |=> phase_q == 3'd0 && bytes_q == '0 && !failed_q && partial_q == 8'd0)
    else $error("string state not cleared after end item");

  // The byte count only moves on a data result or an end item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(adv_i && last_i) && !(res_o.valid && res_o.kind == KIND_DATA) |=> $stable(bytes_q))
    else $error("byte count changed without a data byte");

  // Once failed, no data bytes until the end item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    failed_q |-> !(res_o.valid && res_o.kind == KIND_DATA))
    else $error("data byte emitted after failure");
`endif

endmodule

/* sv/base32hex_stream_decoder_core.sv */
// Base32hex stream decoder, top level: input stage, capacity register, output stage.
// Instantiates b32d_char_class and b32d_packer.
// Depends on b32d_pkg.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one ASCII character per
//   transaction in ch_i; last_i = 1 marks the end of the string (ch_i ignored).
//   Output channel (out_valid_o/out_ready_i) carries at most one result per
//   input transaction: a decoded byte (kind 0) with the running byte count, or
//   at the end of a string kind 1 (ok, total count) or kind 2 (failed, count 0).
//   cfg_we_i/cfg_wdata_i write the capacity register; write it only while idle.
// Timing:
//   A character is captured in the input stage, decoded and packed
//   combinationally, and its result is registered in the output stage as
//   the input stage advances. One character per cycle is sustained while
//   out_ready_i stays high; the input stage and the output stage each hold
//   one transaction.
// Reset:
//   Clears both stages and the string state; capacity returns to 65535.
// Stall:
//   While a result waits in the output stage the input stage still fills, so
//   one more character is taken; then in_ready_o drops until out_ready_i.
module base32hex_stream_decoder_core #(
  parameter int unsigned MAX_CAPACITY = 32'd65535
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        cfg_we_i,
  input  logic [b32d_pkg::CountW-1:0] cfg_wdata_i,
  // input channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  ch_i,
  input  logic                        last_i,
  // output channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  kind_o,
  output logic [7:0]                  data_byte_o,
  output logic [b32d_pkg::CountW-1:0] byte_count_o
);
  import b32d_pkg::*;

  // Parameter cap folded into the counter width
  localparam logic [CountW-1:0] CapClamp =
    (MAX_CAPACITY >= 32'((1 << CountW) - 1)) ? {CountW{1'b1}} : MAX_CAPACITY[CountW-1:0];

  logic [CountW-1:0] capacity_q;
  logic [CountW-1:0] limit;

  logic       s1_valid_q;
  logic [7:0] s1_ch_q;
  logic       s1_last_q;
  logic       adv;

  char_class_t cls;
  result_t     res;

  logic        out_valid_q;
  kind_e       out_kind_q;
  logic [7:0]  out_data_q;
  logic [CountW-1:0] out_count_q;

  // Capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= {CountW{1'b1}};
    end else if (cfg_we_i) begin
      capacity_q <= cfg_wdata_i;
    end
  end

  assign limit = (capacity_q > CapClamp) ? CapClamp : capacity_q;

  // Input stage moves on when the output stage has room
  assign adv        = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_ch_q   <= ch_i;
      s1_last_q <= last_i;
    end
  end

  b32d_char_class u_class (
    .ch_i    (s1_ch_q),
    .class_o (cls)
  );

  b32d_packer u_packer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .last_i  (s1_last_q),
    .class_i (cls),
    .limit_i (limit),
    .res_o   (res)
  );

  // Output stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= res.valid;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res.valid) begin
      out_kind_q  <= res.kind;
      out_data_q  <= res.data;
      out_count_q <= res.count;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = out_kind_q;
  assign data_byte_o  = out_data_q;
  assign byte_count_o = out_count_q;

`ifndef SYNTHESIS
  // Only data results carry a byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KIND_DATA |-> data_byte_o == 8'd0)
    else $error("non-data result carries a byte");

  // Failed strings report a zero count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_FAIL |-> byte_count_o == '0)
    else $error("failed string reports a count");

  // A data byte never exceeds the active limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && res.valid && res.kind == KIND_DATA |-> res.count != '0 && res.count <= limit)
    else $error("data byte beyond capacity");

  // The input stage is never overwritten while it still holds an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !adv |-> !in_ready_o)
    else $error("input stage overrun");
`endif

endmodule

/* dv/b32d_decode_checker.sv */
// b32d_decode_checker: passive checker for the base32hex stream decoder.
// Predicts each result from the accepted characters and compares it against the output channel.
// Depends on b32d_pkg (kind codes, alphabet anchors, count width).
module b32d_decode_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration port of the block
  input  logic                        cfg_we_i,
  input  logic [b32d_pkg::CountW-1:0] cfg_wdata_i,
  // input channel
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic [7:0]                  ch_i,
  input  logic                        last_i,
  // output channel
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic [1:0]                  kind_i,
  input  logic [7:0]                  data_byte_i,
  input  logic [b32d_pkg::CountW-1:0] byte_count_i,
  // status for the testbench top
  output int unsigned                 pending_o,
  output int unsigned                 mismatch_o,
  output int unsigned                 checked_o
);

  timeunit 1ns;
  timeprecision 1ps;

  import b32d_pkg::*;

  // Class codes beyond the 5-bit symbol range
  localparam logic [5:0] SymSkip = 6'd32;
  localparam logic [5:0] SymJunk = 6'd33;

  typedef struct packed {
    kind_e             kind;
    logic [7:0]        data;
    logic [CountW-1:0] count;
  } outcome_t;

  // Predicted string state
  logic [CountW-1:0] capacity;
  logic [2:0]        group_pos;
  logic [7:0]        leftover_bits;
  logic [CountW-1:0] bytes_done;
  logic              string_failed;

  outcome_t    expected_q[$];
  int unsigned pending_count = 0;
  int unsigned mismatches    = 0;
  int unsigned checked       = 0;

  assign pending_o  = pending_count;
  assign mismatch_o = mismatches;
  assign checked_o  = checked;

  // Map a character to its 5-bit value, or to the skip / junk codes
  function automatic logic [5:0] symbol_value(logic [7:0] c);
    if (c >= ChDigit0 && c <= ChDigit9) return 6'(c - ChDigit0);
    if (c >= ChUpperA && c <= ChUpperV) return 6'(c - ChUpperA + 8'd10);
    if (c >= ChLowerA && c <= ChLowerV) return 6'(c - ChLowerA + 8'd10);
    if (c == ChPad || c == ChSpace || (c >= ChTab && c <= ChCr)) return SymSkip;
    return SymJunk;
  endfunction

  task automatic clear_string();
    group_pos     = '0;
    leftover_bits = '0;
    bytes_done    = '0;
    string_failed = 1'b0;
  endtask

  // Advance the predicted state by one accepted transaction
  task automatic decode_item(logic [7:0] c, logic is_last);
    logic [5:0]  v;
    logic [11:0] acc;
    int unsigned nbits;
    int unsigned rest;
    outcome_t    res;
    if (is_last) begin
      res.kind  = string_failed ? KIND_FAIL : KIND_OK;
      res.data  = '0;
      res.count = string_failed ? '0 : bytes_done;
      expected_q.push_back(res);
      clear_string();
    end else if (!string_failed) begin
      v = symbol_value(c);
      if (v == SymJunk) begin
        string_failed = 1'b1;
      end else if (v != SymSkip) begin
        // first bit of this symbol lands in byte index bytes_done
        if (bytes_done >= capacity) begin
          string_failed = 1'b1;
        end else begin
          nbits     = ((group_pos * 5) % 8) + 5;
          acc       = {leftover_bits[6:0], v[4:0]};
          group_pos = group_pos + 3'd1;
          if (nbits >= 8) begin
            rest          = nbits - 8;
            res.kind      = KIND_DATA;
            res.data      = 8'(acc >> rest);
            leftover_bits = 8'(acc & ((12'd1 << rest) - 12'd1));
            bytes_done    = bytes_done + 1'b1;
            res.count     = bytes_done;
            expected_q.push_back(res);
          end else begin
            leftover_bits = acc[7:0];
          end
        end
      end
    end
  endtask

  // Sample both channels at each edge; check outputs before queuing new predictions
  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t exp_res;
    if (!rst_ni) begin
      capacity = 16'hFFFF;
      clear_string();
      expected_q.delete();
      pending_count = 0;
    end else begin
      if (cfg_we_i) capacity = cfg_wdata_i;
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t ERROR: unexpected result kind=%0d data=%02h count=%0d",
                     $realtime, kind_i, data_byte_i, byte_count_i);
        end else begin
          exp_res = expected_q.pop_front();
          checked++;
          if (kind_i !== exp_res.kind || data_byte_i !== exp_res.data ||
              byte_count_i !== exp_res.count) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t ERROR: result %0d expected kind=%0d data=%02h count=%0d,",
                        " got kind=%0d data=%02h count=%0d"},
                       $realtime, checked, exp_res.kind, exp_res.data, exp_res.count,
                       kind_i, data_byte_i, byte_count_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) decode_item(ch_i, last_i);
      pending_count = expected_q.size();
    end
  end

endmodule

/* dv/base32hex_stream_decoder_core_tb.sv */
// base32hex_stream_decoder_core_tb: stimulus and verdict for the base32hex stream decoder.
// Drives directed and random strings under several capacities with bursty input and output stalls.
// Depends on b32d_pkg, base32hex_stream_decoder_core and b32d_decode_checker.
module base32hex_stream_decoder_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import b32d_pkg::*;

  localparam int unsigned IdleLimit   = 2000;  // cycles with no transaction at all
  localparam int unsigned PhaseItems  = 85;    // minimum characters per capacity setting
  localparam int unsigned SettleTicks = 4;     // covers the two-stage pipeline

  logic              clk;
  logic              rst_n     = 1'b0;
  logic              cfg_we    = 1'b0;
  logic [CountW-1:0] cfg_wdata = '0;
  logic              in_valid  = 1'b0;
  logic [7:0]        ch        = '0;
  logic              last      = 1'b0;
  logic              out_ready = 1'b0;
  logic              in_ready;
  logic              out_valid;
  logic [1:0]        kind;
  logic [7:0]        data_byte;
  logic [CountW-1:0] byte_count;

  int unsigned pending;
  int unsigned mismatches;
  int unsigned checked;

  int unsigned burst_left    = 0;
  int unsigned chars_sent    = 0;
  int unsigned strings_sent  = 0;
  int unsigned settings_done = 0;
  int unsigned idle_cycles   = 0;

  // Characters just outside the alphabet and the skip set
  logic [7:0] junk_tbl [16] = '{8'h00, 8'h08, 8'h0E, 8'h1F, 8'h21, 8'h2F, 8'h3A, 8'h3C,
                                8'h3E, 8'h40, 8'h57, 8'h60, 8'h77, 8'h7F, 8'h80, 8'hFF};

  base32hex_stream_decoder_core i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .ch_i         (ch),
    .last_i       (last),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .kind_o       (kind),
    .data_byte_o  (data_byte),
    .byte_count_o (byte_count)
  );

  b32d_decode_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .ch_i         (ch),
    .last_i       (last),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .kind_i       (kind),
    .data_byte_i  (data_byte),
    .byte_count_i (byte_count),
    .pending_o    (pending),
    .mismatch_o   (mismatches),
    .checked_o    (checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver: a rotating stall mask, re-drawn together with the mode, sometimes always ready
  always @(posedge clk or negedge rst_n) begin
    logic [15:0] rx_mask;
    int unsigned rx_tick;
    int unsigned rx_mode;
    if (!rst_n) begin
      rx_tick = 0;
      rx_mode = 0;
      rx_mask = 16'hFFFF;
      out_ready <= 1'b0;
    end else begin
      if (rx_tick % 64 == 0) begin
        rx_mode = $urandom_range(3);
        rx_mask = 16'($urandom) | 16'h0001;
      end
      out_ready <= (rx_mode == 0) ? 1'b1 : rx_mask[rx_tick % 16];
      rx_tick++;
    end
  end

  // Watchdog: ends the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
               idle_cycles, pending);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // One input transaction; bursts of random length separated by random gaps
  task automatic send_char(input logic [7:0] c, input logic is_last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(7) == 0) ? $urandom_range(200, 60) : $urandom_range(24, 1);
      gap = $urandom_range(8, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    in_valid <= 1'b1;
    ch       <= c;
    last     <= is_last;
    do @(posedge clk); while (!in_ready);
    chars_sent++;
    if (is_last) strings_sent++;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
  endtask

  // Stop sending and wait until every predicted result has been taken
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SettleTicks) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CountW-1:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_done++;
  endtask

  function automatic logic [7:0] symbol_char();
    int unsigned v;
    v = $urandom_range(31);
    if (v < 10) return ChDigit0 + 8'(v);
    if ($urandom_range(1) == 0) return ChUpperA + 8'(v - 10);
    return ChLowerA + 8'(v - 10);
  endfunction

  function automatic logic [7:0] skip_char();
    int unsigned r;
    r = $urandom_range(7);
    if (r == 0 || r == 7) return ChSpace;
    if (r == 1) return ChPad;
    return ChTab + 8'(r - 2);
  endfunction

  // Mostly clean strings; some carry a junk character, a few are pure noise
  task automatic send_random_string();
    int unsigned len;
    int unsigned bad_pos;
    int unsigned style;
    int unsigned i;
    len     = ($urandom_range(9) == 0) ? $urandom_range(48) : $urandom_range(20);
    style   = $urandom_range(19);
    bad_pos = $urandom_range(len);
    for (i = 0; i < len; i++) begin
      if (style == 3)
        send_char(8'($urandom), 1'b0);
      else if (style <= 2 && i == bad_pos)
        send_char(junk_tbl[$urandom_range(15)], 1'b0);
      else if ($urandom_range(11) == 0)
        send_char(skip_char(), 1'b0);
      else
        send_char(symbol_char(), 1'b0);
    end
    send_char(8'($urandom), 1'b1);
  endtask

  initial begin
    logic [CountW-1:0] cap_plan [8];
    int unsigned p;
    int unsigned phase_start;

    cap_plan = '{16'd0, 16'd1, 16'd3, 16'($urandom_range(12, 2)), 16'hFFFF,
                 16'($urandom_range(16'hFFFF)), 16'd5, 16'd40};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty string, alphabet extremes with skips, junk, high codes
    send_char(8'h00, 1'b1);
    send_text("0V a\tv=A\r9v0");
    send_char(8'hFF, 1'b1);
    send_text("1W2");
    send_char(8'h5A, 1'b1);
    send_char(8'h0A, 1'b0);
    send_char(8'h0B, 1'b0);
    send_char(8'h0C, 1'b0);
    send_text("7");
    send_char(8'h80, 1'b0);
    send_text("7");
    send_char(8'h00, 1'b1);
    // Capacity overflow on the third symbol
    set_capacity(16'd1);
    send_text("000");
    send_char(8'h00, 1'b1);

    // Random strings under a series of capacities, the extremes among them
    for (p = 0; p < 8; p++) begin
      set_capacity(cap_plan[p]);
      phase_start = chars_sent;
      while (chars_sent - phase_start < PhaseItems) send_random_string();
    end

    drain();
    repeat (6) @(posedge clk);

    $display("Sent %0d characters in %0d strings over %0d capacity settings;",
             chars_sent, strings_sent, settings_done);
    $display("checked %0d results with random input gaps and output stalls.", checked);
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* files.f */
sv/b32d_pkg.sv
sv/b32d_char_class.sv
sv/b32d_packer.sv
sv/base32hex_stream_decoder_core.sv
dv/b32d_decode_checker.sv
dv/base32hex_stream_decoder_core_tb.sv
